// ===== hw/rtl/ffsa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types, constants and codes of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

   localparam int ARENA_BYTES  = 32768;
   localparam int HEADER_BYTES = 24;
   localparam int MAX_SEGMENTS = 64;
   localparam int ADDR_W       = $clog2(MAX_SEGMENTS);
   localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
   localparam int OFF_W        = 15;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOMEM   = 2'd1;
   localparam logic [1:0] ST_BADADDR = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic MODE_ALLOCATE = 1'b0;
   localparam logic MODE_FREE     = 1'b1;

   localparam logic [OFF_W:0] HDR_EXT   = (OFF_W+1)'(HEADER_BYTES);
   localparam logic [OFF_W:0] ARENA_EXT = (OFF_W+1)'(ARENA_BYTES);
   localparam logic [OFF_W-1:0] RESET_BYTES = OFF_W'(ARENA_BYTES - HEADER_BYTES);

   typedef struct packed {
      logic             mode;
      logic [OFF_W-1:0] request_bytes;
      logic [OFF_W-1:0] data_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [OFF_W-1:0] granted_offset;
   } rsp_type;

   typedef struct packed {
      logic             free;
      logic [OFF_W-1:0] start;
      logic [OFF_W-1:0] bytes;
   } seg_type;

   localparam seg_type RESET_SEG = '{free: 1'b1, start: '0, bytes: RESET_BYTES};

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_ARD, S_ACHK, S_SRD, S_SWR, S_SNEW, S_SHOST,
      S_FRD, S_FCHK, S_CRD, S_CCHK, S_CLAST, S_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_READ_IDX, OP_NEXT, OP_EXACT, OP_SPLIT_BEGIN,
      OP_READ_K, OP_MOVE, OP_WRITE_NEW, OP_WRITE_HOST, OP_FOUND,
      OP_COMPACT, OP_FLUSH, OP_FAIL
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       set_res;
      logic [1:0] code;
   } cmd_type;

   typedef struct packed {
      logic             is_free;
      logic             at_end;
      logic             fit;
      logic             exact;
      logic             split_ok;
      logic             full;
      logic             k_at_host;
      logic             addr_hit;
      logic             bad_range;
      logic [CNT_W-1:0] count;
   } stat_type;

endpackage

// ===== hw/rtl/ffsa_ram.sv =====
// ----------------------------------------------------------------------------
// ffsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/ffsa_datapath.sv =====
// ----------------------------------------------------------------------------
// ffsa_datapath
// Segment table, scan counters, split and merge arithmetic, result register.
// ----------------------------------------------------------------------------
module ffsa_datapath (
   input  logic             clock,
   input  logic             reset,
   input  ffsa_pkg::req_type req_item,
   input  ffsa_pkg::cmd_type cmd,
   output ffsa_pkg::stat_type st,
   output ffsa_pkg::rsp_type  rsp_item
);
   import ffsa_pkg::*;

   req_type          req_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] host_ff, host_in;
   logic [CNT_W-1:0] fidx_ff, fidx_in;
   logic [CNT_W-1:0] w_ff, w_in;
   seg_type          host_seg_ff, host_seg_in;
   seg_type          acc_ff, acc_in;
   logic             acc_valid_ff, acc_valid_in;
   logic             valid0_ff, valid0_in;
   logic [ADDR_W-1:0] rd_addr_ff;
   rsp_type          res_ff, res_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   seg_type           wr_seg;
   logic [ADDR_W-1:0] rd_addr;
   logic [$bits(seg_type)-1:0] ram_rdata;
   seg_type           ram_seg, seg, cur;
   logic [OFF_W:0]    req_plus_hdr;
   logic [OFF_W-1:0]  grant;

   ffsa_ram #(.WIDTH($bits(seg_type)), .DEPTH(MAX_SEGMENTS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_seg),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      ram_seg = seg_type'(ram_rdata);
      seg = (valid0_ff && rd_addr_ff == '0) ? RESET_SEG : ram_seg;
      cur = seg;
      if (idx_ff == fidx_ff) begin
         cur.free = 1'b1;
      end
      req_plus_hdr = {1'b0, req_ff.request_bytes} + HDR_EXT;
      grant = OFF_W'({1'b0, host_seg_ff.start} + HDR_EXT);
   end

   always_comb begin
      st.is_free   = (req_ff.mode == MODE_FREE);
      st.at_end    = (idx_ff == count_ff);
      st.fit       = seg.free && (seg.bytes >= req_ff.request_bytes);
      st.exact     = (seg.bytes == req_ff.request_bytes);
      st.split_ok  = ({1'b0, seg.bytes} > req_plus_hdr);
      st.full      = (count_ff == CNT_W'(MAX_SEGMENTS));
      st.k_at_host = (k_ff == host_ff + CNT_W'(1));
      st.addr_hit  = (({1'b0, seg.start} + HDR_EXT) == {1'b0, req_ff.data_offset});
      st.bad_range = ({1'b0, req_ff.data_offset} < HDR_EXT)
                  || ({1'b0, req_ff.data_offset} >= ARENA_EXT);
      st.count     = count_ff;
   end

   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      host_in      = host_ff;
      fidx_in      = fidx_ff;
      w_in         = w_ff;
      host_seg_in  = host_seg_ff;
      acc_in       = acc_ff;
      acc_valid_in = acc_valid_ff;
      res_in       = res_ff;
      rd_addr      = idx_ff[ADDR_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = idx_ff[ADDR_W-1:0];
      wr_seg       = seg;
      unique case (cmd.op)
         OP_LOAD: begin
            idx_in  = '0;
            fidx_in = '1;
            res_in.granted_offset = '0;
         end
         OP_NEXT: begin
            idx_in = idx_ff + CNT_W'(1);
         end
         OP_EXACT: begin
            wr_en       = 1'b1;
            wr_seg.free = 1'b0;
            res_in.granted_offset = OFF_W'({1'b0, seg.start} + HDR_EXT);
         end
         OP_SPLIT_BEGIN: begin
            host_in     = idx_ff;
            host_seg_in = seg;
            k_in        = count_ff;
         end
         OP_READ_K: begin
            rd_addr = ADDR_W'(k_ff - CNT_W'(1));
         end
         OP_MOVE: begin
            wr_en   = 1'b1;
            wr_addr = k_ff[ADDR_W-1:0];
            wr_seg  = seg;
            k_in    = k_ff - CNT_W'(1);
         end
         OP_WRITE_NEW: begin
            wr_en        = 1'b1;
            wr_addr      = ADDR_W'(host_ff + CNT_W'(1));
            wr_seg.free  = 1'b1;
            wr_seg.start = OFF_W'({1'b0, host_seg_ff.start} + req_plus_hdr);
            wr_seg.bytes = OFF_W'({1'b0, host_seg_ff.bytes} - req_plus_hdr);
         end
         OP_WRITE_HOST: begin
            wr_en        = 1'b1;
            wr_addr      = host_ff[ADDR_W-1:0];
            wr_seg.free  = 1'b0;
            wr_seg.start = host_seg_ff.start;
            wr_seg.bytes = req_ff.request_bytes;
            count_in     = count_ff + CNT_W'(1);
            res_in.granted_offset = grant;
         end
         OP_FOUND: begin
            fidx_in      = idx_ff;
            idx_in       = '0;
            w_in         = '0;
            acc_valid_in = 1'b0;
         end
         OP_COMPACT: begin
            idx_in = idx_ff + CNT_W'(1);
            if (!acc_valid_ff) begin
               acc_in       = cur;
               acc_valid_in = 1'b1;
            end else if (acc_ff.free && cur.free) begin
               acc_in.bytes = OFF_W'({1'b0, acc_ff.bytes} + {1'b0, cur.bytes} + HDR_EXT);
            end else begin
               wr_en   = 1'b1;
               wr_addr = w_ff[ADDR_W-1:0];
               wr_seg  = acc_ff;
               w_in    = w_ff + CNT_W'(1);
               acc_in  = cur;
            end
         end
         OP_FLUSH: begin
            wr_en    = 1'b1;
            wr_addr  = w_ff[ADDR_W-1:0];
            wr_seg   = acc_ff;
            count_in = w_ff + CNT_W'(1);
         end
         default: begin
         end
      endcase
      if (cmd.set_res) begin
         res_in.status = cmd.code;
      end
   end

   assign valid0_in = valid0_ff && !(wr_en && wr_addr == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= CNT_W'(1);
         valid0_ff <= 1'b1;
      end else begin
         count_ff  <= count_in;
         valid0_ff <= valid0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         req_ff <= req_item;
      end
      idx_ff       <= idx_in;
      k_ff         <= k_in;
      host_ff      <= host_in;
      fidx_ff      <= fidx_in;
      w_ff         <= w_in;
      host_seg_ff  <= host_seg_in;
      acc_ff       <= acc_in;
      acc_valid_ff <= acc_valid_in;
      res_ff       <= res_in;
      rd_addr_ff   <= rd_addr;
   end

   assign rsp_item = res_ff;

endmodule

// ===== hw/rtl/ffsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer for allocate scan and split, free lookup and table compaction.
// ----------------------------------------------------------------------------
module ffsa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  ffsa_pkg::stat_type st,
   output ffsa_pkg::cmd_type  cmd,
   output logic               busy,
   output logic               rsp_valid
);
   import ffsa_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (start) state_in = S_DISPATCH;
         S_DISPATCH: state_in = st.is_free ? S_FRD : S_ARD;
         S_ARD:      state_in = st.at_end ? S_DONE : S_ACHK;
         S_ACHK: begin
            priority if (!st.fit)     state_in = S_ARD;
            else if (st.exact)        state_in = S_DONE;
            else if (!st.split_ok)    state_in = S_DONE;
            else if (st.full)         state_in = S_DONE;
            else                      state_in = S_SRD;
         end
         S_SRD:      state_in = st.k_at_host ? S_SNEW : S_SWR;
         S_SWR:      state_in = S_SRD;
         S_SNEW:     state_in = S_SHOST;
         S_SHOST:    state_in = S_DONE;
         S_FRD:      state_in = (st.bad_range || st.at_end) ? S_DONE : S_FCHK;
         S_FCHK:     state_in = st.addr_hit ? S_CRD : S_FRD;
         S_CRD:      state_in = st.at_end ? S_CLAST : S_CCHK;
         S_CCHK:     state_in = S_CRD;
         S_CLAST:    state_in = S_DONE;
         S_DONE:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '{op: OP_NONE, set_res: 1'b0, code: ST_OK};
      unique case (state_ff)
         S_IDLE:     if (start) cmd.op = OP_LOAD;
         S_ARD: begin
            if (st.at_end) cmd = '{op: OP_FAIL, set_res: 1'b1, code: ST_NOMEM};
            else           cmd.op = OP_READ_IDX;
         end
         S_ACHK: begin
            priority if (!st.fit)  cmd.op = OP_NEXT;
            else if (st.exact)     cmd = '{op: OP_EXACT, set_res: 1'b1, code: ST_OK};
            else if (!st.split_ok) cmd = '{op: OP_FAIL, set_res: 1'b1, code: ST_NOMEM};
            else if (st.full)      cmd = '{op: OP_FAIL, set_res: 1'b1, code: ST_FULL};
            else                   cmd.op = OP_SPLIT_BEGIN;
         end
         S_SRD:      if (!st.k_at_host) cmd.op = OP_READ_K;
         S_SWR:      cmd.op = OP_MOVE;
         S_SNEW:     cmd.op = OP_WRITE_NEW;
         S_SHOST:    cmd = '{op: OP_WRITE_HOST, set_res: 1'b1, code: ST_OK};
         S_FRD: begin
            if (st.bad_range || st.at_end)
               cmd = '{op: OP_FAIL, set_res: 1'b1, code: ST_BADADDR};
            else
               cmd.op = OP_READ_IDX;
         end
         S_FCHK:     cmd.op = st.addr_hit ? OP_FOUND : OP_NEXT;
         S_CRD:      if (!st.at_end) cmd.op = OP_READ_IDX;
         S_CCHK:     cmd.op = OP_COMPACT;
         S_CLAST:    cmd = '{op: OP_FLUSH, set_res: 1'b1, code: ST_OK};
         default:    cmd.op = OP_NONE;
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/first_fit_segment_allocator.sv =====
// Allocate scans segments in address order for the first free one that fits; on a split the
// later entries shift up one place and the remainder becomes a new free segment after the host.
// Free searches for the segment at the offset; a hit compacts the table, merging free neighbours.
// The longest beat is a free in a full table.
// One beat at a time; busy stays high until the result strobe, which cannot be stalled.
// Reset: one free segment spanning the arena minus a header, no clearing pass.
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit allocator over an address-ordered segment table with split and merge.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffsa_pkg::req_type req_item,
   output logic              rsp_valid,
   output ffsa_pkg::rsp_type rsp_item
);
   import ffsa_pkg::*;

   cmd_type  cmd;
   stat_type st;

   ffsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .st        (st),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   ffsa_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .st       (st),
      .rsp_item (rsp_item)
   );

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      st.count != '0 && st.count <= CNT_W'(MAX_SEGMENTS))
      else $error("segment count out of range");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("busy after result");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("beat not taken");

   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != ST_OK |-> rsp_item.granted_offset == '0)
      else $error("grant on failure");

endmodule
